### sv/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the sticky channel reader: item layouts,
// command kinds, buffer geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package scr_pkg;

    // Buffer geometry.
    localparam int CHANNELS     = 4;
    localparam int BUFFER_DEPTH = 2048;
    localparam int CH_W         = 2;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = IDX_W + 1;
    localparam int MEM_DEPTH    = CHANNELS * BUFFER_DEPTH;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    // Field and register widths.
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 8;
    localparam int THRESH_W = 12;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 12;

    // Reset values of the configuration registers.
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(256);
    localparam logic [TICK_W-1:0]   LIMIT_RESET  = TICK_W'(20);
    localparam logic [TICK_W-1:0]   TICK_MAX     = '1;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_EMPTY_THRESHOLD = 1'b0;
    localparam logic [CFG_IW-1:0] REG_IDLE_LIMIT      = 1'b1;

    // Opcodes of an input item.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]        opcode;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] byte_in;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic              got_byte;
        logic [BYTE_W-1:0] byte_out;
        logic [CH_W-1:0]   channel_out;
        logic              flow_release;
        logic              flushed;
        logic              dropped;
    } t_out_item;

    // Classified command handed from the front to the engine.
    typedef enum logic [1:0] {
        K_NOP,
        K_PUSH,
        K_POP,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // Configuration write.
    typedef struct packed {
        logic              we;
        logic [CFG_IW-1:0] idx;
        logic [CFG_DW-1:0] data;
    } t_cfg_wr;

endpackage

### sv/sticky_channel_reader_idle_timeout_top.sv
// ----------------------------------------------------------------------------
// sticky_channel_reader_idle_timeout_top
// Per-channel byte ring buffers read by one sticky reader with idle timeout.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            i_item (t_in_item)
//   result    out        empty / pop            o_item (t_out_item)
//   config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// Push, tick and other items complete in ST_EXEC; a pop that returns a byte also
// passes ST_READ, set by the registered read of the single-port byte memory.
// A two-entry command queue and a two-entry result queue let the input and
// result sides stall independently of the engine.
// Reset is synchronous and clears all indexes, fill counts and session state;
// the byte memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sticky_channel_reader_idle_timeout_top import scr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_item,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_item,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_take;
    logic      res_space;
    logic      res_wr;
    t_out_item res;
    t_cfg_wr   cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Front: accept and classify.
    scr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back: carry out commands.
    scr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_space (res_space),
        .o_res_wr    (res_wr),
        .o_res       (res)
    );

    // Result queue.
    scr_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_item  (res),
        .o_space (res_space),
        .o_empty (empty),
        .o_item  (o_item),
        .i_pop   (pop)
    );

endmodule

### sv/scr_front.sv
// ----------------------------------------------------------------------------
// scr_front
// Accepts input items, classifies them into commands and holds them in a
// two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
module scr_front import scr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       enq;
    logic       deq;

    // Classify the incoming item.
    always_comb begin
        cls.channel = i_item.channel;
        cls.data    = i_item.byte_in;
        unique case (i_item.opcode)
            OP_PUSH: cls.kind = K_PUSH;
            OP_POP:  cls.kind = K_POP;
            OP_TICK: cls.kind = K_TICK;
            default: cls.kind = K_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign enq         = i_push && !o_full;
    assign deq         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_head];

    always_comb begin
        n_cnt = r_cnt;
        if (enq && !deq) begin
            n_cnt = r_cnt + 2'd1;
        end else if (deq && !enq) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_tail] <= cls;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (enq) begin
                r_tail <= ~r_tail;
            end
            if (deq) begin
                r_head <= ~r_head;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/scr_res_queue.sv
// ----------------------------------------------------------------------------
// scr_res_queue
// Two-entry queue of result items between the engine and the result port.
// ----------------------------------------------------------------------------
module scr_res_queue import scr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_out_item i_item,
    output logic      o_space,
    output logic      o_empty,
    output t_out_item o_item,
    input  logic      i_pop
);

    t_out_item  r_q [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       deq;

    assign o_space = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_q[r_head];
    assign deq     = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !deq) begin
            n_cnt = r_cnt + 2'd1;
        end else if (deq && !i_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_tail] <= i_item;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_tail <= ~r_tail;
            end
            if (deq) begin
                r_head <= ~r_head;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/scr_engine.sv
// ----------------------------------------------------------------------------
// scr_engine
// Carries out commands: per-channel ring buffers in one byte memory, the
// sticky session lock, the idle timer and the configuration registers.
// ----------------------------------------------------------------------------
module scr_engine import scr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    input  logic      i_res_space,
    output logic      o_res_wr,
    output t_out_item o_res
);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_wr_idx [CHANNELS];
    logic [IDX_W-1:0]    n_wr_idx [CHANNELS];
    logic [IDX_W-1:0]    r_rd_idx [CHANNELS];
    logic [IDX_W-1:0]    n_rd_idx [CHANNELS];
    logic [FILL_W-1:0]   r_fill   [CHANNELS];
    logic [FILL_W-1:0]   n_fill   [CHANNELS];
    logic                r_locked, n_locked;
    logic [CH_W-1:0]     r_lock_ch, n_lock_ch;
    logic                r_armed, n_armed;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic [THRESH_W-1:0] r_thresh;
    logic [TICK_W-1:0]   r_limit;
    t_out_item           r_pend, n_pend;

    logic [BYTE_W-1:0]   r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]   r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [MEM_AW-1:0]   mem_addr;

    logic [CH_W-1:0]     sel_ch;
    logic                sel_found;
    logic [CH_W-1:0]     rd_ch;
    logic [FILL_W-1:0]   fill_after;

    // Lowest-numbered channel holding data.
    always_comb begin
        sel_ch    = '0;
        sel_found = 1'b0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_fill[i] != '0) begin
                sel_ch    = CH_W'(i);
                sel_found = 1'b1;
            end
        end
    end

    // Channel a pop reads from, and its fill once the byte is gone.
    assign rd_ch      = r_locked ? r_lock_ch : sel_ch;
    assign fill_after = r_fill[rd_ch] - FILL_W'(1);

    // Command execution.
    always_comb begin
        n_state   = r_state;
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_fill    = r_fill;
        n_locked  = r_locked;
        n_lock_ch = r_lock_ch;
        n_armed   = r_armed;
        n_ticks   = r_ticks;
        n_pend    = r_pend;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        o_cmd_take = 1'b0;
        o_res_wr  = 1'b0;
        o_res     = '0;

        unique case (r_state)
            ST_EXEC: begin
                if (i_cmd_valid && i_res_space) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        K_PUSH: begin
                            o_res_wr = 1'b1;
                            if (32'(i_cmd.channel) < CHANNELS) begin
                                o_res.channel_out = i_cmd.channel;
                                if (r_fill[i_cmd.channel] >= FILL_W'(BUFFER_DEPTH)) begin
                                    o_res.dropped = 1'b1;
                                end else begin
                                    mem_we   = 1'b1;
                                    mem_addr = (MEM_AW'(i_cmd.channel) << IDX_W)
                                             | MEM_AW'(r_wr_idx[i_cmd.channel]);
                                    n_wr_idx[i_cmd.channel] =
                                        (r_wr_idx[i_cmd.channel] == IDX_W'(BUFFER_DEPTH - 1))
                                        ? '0 : r_wr_idx[i_cmd.channel] + IDX_W'(1);
                                    n_fill[i_cmd.channel] =
                                        r_fill[i_cmd.channel] + FILL_W'(1);
                                end
                            end
                        end
                        K_POP: begin
                            if ((!r_locked && sel_found)
                                    || (r_locked && r_fill[r_lock_ch] != '0)) begin
                                // A byte is available: start the memory read.
                                mem_re   = 1'b1;
                                mem_addr = (MEM_AW'(rd_ch) << IDX_W)
                                         | MEM_AW'(r_rd_idx[rd_ch]);
                                n_rd_idx[rd_ch] =
                                    (r_rd_idx[rd_ch] == IDX_W'(BUFFER_DEPTH - 1))
                                    ? '0 : r_rd_idx[rd_ch] + IDX_W'(1);
                                n_fill[rd_ch] = fill_after;
                                n_locked  = 1'b1;
                                n_lock_ch = rd_ch;
                                n_armed   = 1'b0;
                                n_ticks   = '0;
                                n_pend    = '0;
                                n_pend.got_byte    = 1'b1;
                                n_pend.channel_out = rd_ch;
                                n_pend.flow_release =
                                    r_locked && (fill_after < r_thresh);
                                n_state = ST_READ;
                            end else begin
                                o_res_wr = 1'b1;
                                if (r_locked && !r_armed) begin
                                    n_armed = 1'b1;
                                    n_ticks = '0;
                                end else if (r_locked && (r_ticks > r_limit)) begin
                                    // Idle timeout: flush the ring and unlock.
                                    n_wr_idx[r_lock_ch] = '0;
                                    n_rd_idx[r_lock_ch] = '0;
                                    n_fill[r_lock_ch]   = '0;
                                    o_res.channel_out   = r_lock_ch;
                                    o_res.flow_release  = 1'b1;
                                    o_res.flushed       = 1'b1;
                                    n_locked  = 1'b0;
                                    n_lock_ch = '0;
                                    n_armed   = 1'b0;
                                    n_ticks   = '0;
                                end
                            end
                        end
                        K_TICK: begin
                            o_res_wr = 1'b1;
                            if (r_armed && (r_ticks != TICK_MAX)) begin
                                n_ticks = r_ticks + TICK_W'(1);
                            end
                        end
                        default: begin
                            o_res_wr = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The slot reserved at issue is still free.
                o_res_wr       = 1'b1;
                o_res          = r_pend;
                o_res.byte_out = r_rd_data;
                n_state        = ST_EXEC;
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase
    end

    // Byte memory, single port with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // Pending result held while the memory read completes.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_EXEC;
            r_locked  <= 1'b0;
            r_lock_ch <= '0;
            r_armed   <= 1'b0;
            r_ticks   <= '0;
            r_thresh  <= THRESH_RESET;
            r_limit   <= LIMIT_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_wr_idx[i] <= '0;
                r_rd_idx[i] <= '0;
                r_fill[i]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_locked  <= n_locked;
            r_lock_ch <= n_lock_ch;
            r_armed   <= n_armed;
            r_ticks   <= n_ticks;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_fill    <= n_fill;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_EMPTY_THRESHOLD: r_thresh <= i_cfg.data[THRESH_W-1:0];
                    REG_IDLE_LIMIT:      r_limit  <= i_cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
